// File: hw/rtl/gbbc_pkg.sv
// Shared constants and codes for the cartridge bank controller.
`timescale 1ns / 1ps

package gbbc_pkg;

   localparam int RomBankBitsDefault = 9;
   localparam int RamBankBitsDefault = 6;

   localparam int RomBankFieldWidth = 9;
   localparam int RamBankFieldWidth = 6;
   localparam int MemAddrWidth      = 23;
   localparam int BusAddrWidth      = 16;
   localparam int BusDataWidth      = 8;
   localparam int KindWidth         = 2;
   localparam int ModeWidth         = 3;
   localparam int CsrAddrWidth      = 4;
   localparam int CsrDataWidth      = 32;
   localparam int RomOffsetWidth    = 14;
   localparam int RamOffsetWidth    = 13;

   localparam logic [KindWidth-1:0] KindNone     = 2'd0;
   localparam logic [KindWidth-1:0] KindRomRead  = 2'd1;
   localparam logic [KindWidth-1:0] KindRamRead  = 2'd2;
   localparam logic [KindWidth-1:0] KindRamWrite = 2'd3;

   localparam logic [ModeWidth-1:0] MapNone      = 3'd0;
   localparam logic [ModeWidth-1:0] MapMbc1      = 3'd1;
   localparam logic [ModeWidth-1:0] MapMbc2      = 3'd2;
   localparam logic [ModeWidth-1:0] MapMbc3      = 3'd3;
   localparam logic [ModeWidth-1:0] MapMbc3Timer = 3'd4;
   localparam logic [ModeWidth-1:0] MapMbc5      = 3'd5;

   localparam logic [1:0] RegMapperMode  = 2'd0;
   localparam logic [1:0] RegRomBankMask = 2'd1;
   localparam logic [1:0] RegRamBankMask = 2'd2;

   localparam logic [RomBankFieldWidth-1:0] RomMaskReset = 9'h1FF;
   localparam logic [RamBankFieldWidth-1:0] RamMaskReset = 6'h3F;

   localparam logic [3:0] RamEnableKey = 4'hA;

   // Address bits 15:13 of the save RAM window.
   localparam logic [2:0] RamWindow = 3'b101;

   // Upper address bits 15:13 that select MBC register groups.
   localparam logic [2:0] GrpEnable  = 3'd0;
   localparam logic [2:0] GrpRomBank = 3'd1;
   localparam logic [2:0] GrpUpper   = 3'd2;
   localparam logic [2:0] GrpMode    = 3'd3;

   // Address bits 15:12 for the MBC5 registers.
   localparam logic [3:0] Mbc5EnableLo = 4'h0;
   localparam logic [3:0] Mbc5EnableHi = 4'h1;
   localparam logic [3:0] Mbc5RomLow   = 4'h2;
   localparam logic [3:0] Mbc5RomHigh  = 4'h3;
   localparam logic [3:0] Mbc5RamLo    = 4'h4;
   localparam logic [3:0] Mbc5RamHi    = 4'h5;

endpackage

// File: hw/rtl/gbbc_intf.sv
// Valid/ready channel interfaces for the bus access and result beats.
`timescale 1ns / 1ps

interface gbbc_req_if;
   logic                                valid;
   logic                                ready;
   logic                                action;
   logic [gbbc_pkg::BusAddrWidth-1:0]   bus_address;
   logic [gbbc_pkg::BusDataWidth-1:0]   bus_data;

   modport source (output valid, action, bus_address, bus_data, input ready);
   modport sink   (input valid, action, bus_address, bus_data, output ready);
endinterface

interface gbbc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [gbbc_pkg::KindWidth-1:0]      access_kind;
   logic [gbbc_pkg::MemAddrWidth-1:0]   memory_address;
   logic [gbbc_pkg::BusDataWidth-1:0]   write_byte;

   modport source (output valid, access_kind, memory_address, write_byte, input ready);
   modport sink   (input valid, access_kind, memory_address, write_byte, output ready);
endinterface

// File: hw/rtl/gameboy_bank_controller_top.sv
// Cartridge bank controller top level: bank registers, access decode and CSR port.
`timescale 1ns / 1ps

// Each accepted bus access beat produces exactly one result beat, in order. The block takes
// one beat per clock while the result side does not stall; a beat is held in an input
// register, decoded against the bank registers in a single pass, and its result is loaded
// into the output register once that register is free or being taken by the result side.
// Bank register updates from a write take effect for the very next access.
// Configuration registers (mapper mode at 0x0, ROM bank mask at 0x4, RAM bank mask at 0x8)
// must be written only while no access is in flight.
module gameboy_bank_controller_top #(
   parameter int ROM_BANK_BITS = gbbc_pkg::RomBankBitsDefault,
   parameter int RAM_BANK_BITS = gbbc_pkg::RamBankBitsDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   gbbc_req_if.sink                             req_bus,
   gbbc_rsp_if.source                           rsp_bus,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [gbbc_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [gbbc_pkg::CsrDataWidth-1:0]    pwdata,
   output logic [gbbc_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                 pready
);

   localparam int RomFieldW = gbbc_pkg::RomBankFieldWidth;
   localparam int RamFieldW = gbbc_pkg::RamBankFieldWidth;
   localparam int MemW      = gbbc_pkg::MemAddrWidth;
   localparam int CsrW      = gbbc_pkg::CsrDataWidth;
   localparam int ModeW     = gbbc_pkg::ModeWidth;

   // Configuration registers.
   logic [ModeW-1:0]     mapper_mode_ff;
   logic [RomFieldW-1:0] rom_bank_limit_mask_ff;
   logic [RamFieldW-1:0] ram_bank_limit_mask_ff;
   logic                 csr_write;

   // Bank state.
   logic [ROM_BANK_BITS-1:0] rom_bank_ff, rom_bank_in;
   logic [RAM_BANK_BITS-1:0] ram_bank_ff, ram_bank_in;
   logic                     ram_enabled_ff, ram_enabled_in;
   logic                     mbc1_ram_mode_ff, mbc1_ram_mode_in;

   // Input register.
   logic                                s1_valid_ff;
   logic                                s1_action_ff;
   logic [gbbc_pkg::BusAddrWidth-1:0]   s1_addr_ff;
   logic [gbbc_pkg::BusDataWidth-1:0]   s1_data_ff;

   // Output register.
   logic                                out_valid_ff;
   logic [gbbc_pkg::KindWidth-1:0]      out_kind_ff, res_kind;
   logic [MemW-1:0]                     out_addr_ff, res_addr;
   logic [gbbc_pkg::BusDataWidth-1:0]   out_byte_ff, res_byte;

   logic advance;

   // Decode signals.
   logic [3:0]           hi;
   logic                 ram_win;
   logic                 mapper_ok;
   logic                 upd;
   logic                 en_value;
   logic [RomFieldW-1:0] rom_ext;
   logic [RomFieldW-1:0] rom_cand;
   logic [RomFieldW-1:0] rom_masked;
   logic [RamFieldW-1:0] ram_cand;
   logic [RamFieldW-1:0] ram_masked;
   logic                 rom_set;
   logic                 ram_set;
   logic                 en_set;
   logic                 mode_set;
   logic [MemW-1:0]      rom_addr;
   logic [MemW-1:0]      ram_addr;

   // ---------------------------------------------------------------- CSR port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mapper_mode_ff         <= gbbc_pkg::MapNone;
         rom_bank_limit_mask_ff <= gbbc_pkg::RomMaskReset;
         ram_bank_limit_mask_ff <= gbbc_pkg::RamMaskReset;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            gbbc_pkg::RegMapperMode:  mapper_mode_ff         <= pwdata[ModeW-1:0];
            gbbc_pkg::RegRomBankMask: rom_bank_limit_mask_ff <= pwdata[RomFieldW-1:0];
            gbbc_pkg::RegRamBankMask: ram_bank_limit_mask_ff <= pwdata[RamFieldW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         gbbc_pkg::RegMapperMode:  prdata = CsrW'(mapper_mode_ff);
         gbbc_pkg::RegRomBankMask: prdata = CsrW'(rom_bank_limit_mask_ff);
         gbbc_pkg::RegRamBankMask: prdata = CsrW'(ram_bank_limit_mask_ff);
         default:                  prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- handshake
   assign advance       = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_action_ff <= req_bus.action;
         s1_addr_ff   <= req_bus.bus_address;
         s1_data_ff   <= req_bus.bus_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_kind_ff <= res_kind;
         out_addr_ff <= res_addr;
         out_byte_ff <= res_byte;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.access_kind    = out_kind_ff;
   assign rsp_bus.memory_address = out_addr_ff;
   assign rsp_bus.write_byte     = out_byte_ff;

   // ---------------------------------------------------------------- bank register writes
   assign hi        = s1_addr_ff[15:12];
   assign ram_win   = (hi[3:1] == gbbc_pkg::RamWindow);
   assign mapper_ok = (mapper_mode_ff >= gbbc_pkg::MapMbc1)
                   && (mapper_mode_ff <= gbbc_pkg::MapMbc5);
   assign upd       = advance && s1_action_ff && mapper_ok && !ram_win;
   assign en_value  = (s1_data_ff[3:0] == gbbc_pkg::RamEnableKey);
   assign rom_ext   = RomFieldW'(rom_bank_ff);

   always_comb begin
      rom_cand = '0;
      ram_cand = '0;
      rom_set  = 1'b0;
      ram_set  = 1'b0;
      en_set   = 1'b0;
      mode_set = 1'b0;
      unique case (mapper_mode_ff) inside
         gbbc_pkg::MapMbc1: begin
            unique case (hi[3:1])
               gbbc_pkg::GrpEnable: en_set = 1'b1;
               gbbc_pkg::GrpRomBank: begin
                  rom_set  = 1'b1;
                  rom_cand = {rom_ext[8:7], rom_ext[6:5],
                              (s1_data_ff[4:0] == 5'd0) ? 5'd1 : s1_data_ff[4:0]};
                  rom_cand[8:7] = 2'b00;
               end
               gbbc_pkg::GrpUpper: begin
                  if (mbc1_ram_mode_ff) begin
                     ram_set  = 1'b1;
                     ram_cand = RamFieldW'(s1_data_ff[1:0]);
                  end else begin
                     rom_set  = 1'b1;
                     rom_cand = {2'b00, s1_data_ff[1:0], rom_ext[4:0]};
                  end
               end
               gbbc_pkg::GrpMode: mode_set = 1'b1;
               default: ;
            endcase
         end
         gbbc_pkg::MapMbc2: begin
            if (hi[3:2] == 2'b00) begin
               if (s1_addr_ff[8]) begin
                  en_set = 1'b1;
               end else begin
                  rom_set  = 1'b1;
                  rom_cand = RomFieldW'((s1_data_ff[3:0] == 4'd0) ? 4'd1 : s1_data_ff[3:0]);
               end
            end
         end
         gbbc_pkg::MapMbc3, gbbc_pkg::MapMbc3Timer: begin
            unique case (hi[3:1])
               gbbc_pkg::GrpEnable: en_set = 1'b1;
               gbbc_pkg::GrpRomBank: begin
                  rom_set  = 1'b1;
                  rom_cand = RomFieldW'((s1_data_ff[6:0] == 7'd0) ? 7'd1 : s1_data_ff[6:0]);
               end
               gbbc_pkg::GrpUpper: begin
                  ram_set  = 1'b1;
                  ram_cand = RamFieldW'(s1_data_ff[3:0]);
               end
               default: ;
            endcase
         end
         gbbc_pkg::MapMbc5: begin
            unique case (hi) inside
               gbbc_pkg::Mbc5EnableLo, gbbc_pkg::Mbc5EnableHi: en_set = 1'b1;
               gbbc_pkg::Mbc5RomLow: begin
                  rom_set  = 1'b1;
                  rom_cand = {rom_ext[8], s1_data_ff};
               end
               gbbc_pkg::Mbc5RomHigh: begin
                  rom_set  = 1'b1;
                  rom_cand = {s1_data_ff[0], rom_ext[7:0]};
               end
               gbbc_pkg::Mbc5RamLo, gbbc_pkg::Mbc5RamHi: begin
                  ram_set  = 1'b1;
                  ram_cand = RamFieldW'(s1_data_ff[3:0]);
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   assign rom_masked = rom_cand & rom_bank_limit_mask_ff;
   assign ram_masked = ram_cand & ram_bank_limit_mask_ff;

   always_comb begin
      rom_bank_in      = rom_bank_ff;
      ram_bank_in      = ram_bank_ff;
      ram_enabled_in   = ram_enabled_ff;
      mbc1_ram_mode_in = mbc1_ram_mode_ff;
      if (upd) begin
         if (rom_set) begin
            rom_bank_in = rom_masked[ROM_BANK_BITS-1:0];
         end
         if (ram_set) begin
            ram_bank_in = ram_masked[RAM_BANK_BITS-1:0];
         end
         if (en_set) begin
            ram_enabled_in = en_value;
         end
         if (mode_set) begin
            mbc1_ram_mode_in = s1_data_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bank_ff      <= ROM_BANK_BITS'(1);
         ram_bank_ff      <= '0;
         ram_enabled_ff   <= 1'b0;
         mbc1_ram_mode_ff <= 1'b0;
      end else begin
         rom_bank_ff      <= rom_bank_in;
         ram_bank_ff      <= ram_bank_in;
         ram_enabled_ff   <= ram_enabled_in;
         mbc1_ram_mode_ff <= mbc1_ram_mode_in;
      end
   end

   // ---------------------------------------------------------------- result decode
   assign rom_addr = (MemW'(rom_bank_ff) << gbbc_pkg::RomOffsetWidth)
                   | MemW'(s1_addr_ff[gbbc_pkg::RomOffsetWidth-1:0]);
   assign ram_addr = (MemW'(ram_bank_ff) << gbbc_pkg::RamOffsetWidth)
                   | MemW'(s1_addr_ff[gbbc_pkg::RamOffsetWidth-1:0]);

   always_comb begin
      res_kind = gbbc_pkg::KindNone;
      res_addr = '0;
      res_byte = '0;
      if (s1_action_ff) begin
         if (mapper_ok && ram_win && ram_enabled_ff) begin
            res_kind = gbbc_pkg::KindRamWrite;
            res_addr = ram_addr;
            res_byte = s1_data_ff;
         end
      end else if (s1_addr_ff[15:14] == 2'b00) begin
         res_kind = gbbc_pkg::KindRomRead;
         res_addr = MemW'(s1_addr_ff);
      end else if (!s1_addr_ff[15]) begin
         res_kind = gbbc_pkg::KindRomRead;
         res_addr = rom_addr;
      end else if (ram_win && ram_enabled_ff) begin
         res_kind = gbbc_pkg::KindRamRead;
         res_addr = ram_addr;
      end
   end

   // ---------------------------------------------------------------- assertions
   a_none_is_blank: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_kind_ff == gbbc_pkg::KindNone)
         |-> (out_addr_ff == '0) && (out_byte_ff == '0))
      else $error("Result with no access carries a nonzero address or byte.");

   a_byte_only_on_write: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_kind_ff != gbbc_pkg::KindRamWrite) |-> (out_byte_ff == '0))
      else $error("Write byte set on a result that is not a save RAM write.");

   a_ram_needs_enable: assert property (@(posedge clock) disable iff (reset)
      advance && ((res_kind == gbbc_pkg::KindRamRead) || (res_kind == gbbc_pkg::KindRamWrite))
         |-> ram_enabled_ff)
      else $error("Save RAM access issued while RAM is disabled.");

   a_state_only_on_beat: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(ram_enabled_ff) && $stable(rom_bank_ff) && $stable(ram_bank_ff))
      else $error("Bank state changed without an access beat.");

   a_beat_reaches_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("Decoded access beat did not reach the output register.");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the cartridge bank controller top level.
`timescale 1ns / 1ps

module testbench;

   localparam logic ActRead  = 1'b0;
   localparam logic ActWrite = 1'b1;

   localparam int PhaseCount     = 10;
   localparam int RandomPerPhase = 140;
   localparam int HoldPhase      = 4;
   localparam int HoldCycles     = 400;
   localparam int DrainIndex     = 70;
   localparam int SettleCycles   = 6;
   localparam int ReportLimit    = 10;

   localparam logic [gbbc_pkg::ModeWidth-1:0] PhaseMapper [PhaseCount] = '{
      gbbc_pkg::MapMbc1, gbbc_pkg::MapMbc2, gbbc_pkg::MapMbc3, gbbc_pkg::MapMbc3Timer,
      gbbc_pkg::MapMbc5, gbbc_pkg::MapMbc1, gbbc_pkg::MapMbc5, gbbc_pkg::MapMbc3,
      gbbc_pkg::MapNone, gbbc_pkg::MapMbc5
   };
   localparam logic [gbbc_pkg::RomBankFieldWidth-1:0] PhaseRomMask [PhaseCount] = '{
      9'h1FF, 9'h00F, 9'h07F, 9'h000, 9'h1FF, 9'h01F, 9'h0FF, 9'h1FF, 9'h1FF, 9'h155
   };
   localparam logic [gbbc_pkg::RamBankFieldWidth-1:0] PhaseRamMask [PhaseCount] = '{
      6'h3F, 6'h03, 6'h0F, 6'h00, 6'h3F, 6'h03, 6'h3F, 6'h2A, 6'h3F, 6'h3F
   };
   localparam int SendIdle  [4] = '{0, 88, 0, 16};
   localparam int RecvStall [4] = '{0, 0, 88, 16};

   typedef struct packed {
      logic                              action;
      logic [gbbc_pkg::BusAddrWidth-1:0] bus_address;
      logic [gbbc_pkg::BusDataWidth-1:0] bus_data;
   } bus_access_type;

   typedef struct packed {
      logic [gbbc_pkg::KindWidth-1:0]    access_kind;
      logic [gbbc_pkg::MemAddrWidth-1:0] memory_address;
      logic [gbbc_pkg::BusDataWidth-1:0] write_byte;
   } mem_access_type;

   typedef struct {
      bus_access_type beat;
      bit             after_drain;
   } queued_access_type;

   logic                              clock;
   logic                              reset;
   logic                              psel;
   logic                              penable;
   logic                              pwrite;
   logic [gbbc_pkg::CsrAddrWidth-1:0] paddr;
   logic [gbbc_pkg::CsrDataWidth-1:0] pwdata;
   logic [gbbc_pkg::CsrDataWidth-1:0] prdata;
   logic                              pready;

   gbbc_req_if req_bus ();
   gbbc_rsp_if rsp_bus ();

   gameboy_bank_controller_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   logic [gbbc_pkg::ModeWidth-1:0]         cfg_mapper;
   logic [gbbc_pkg::RomBankFieldWidth-1:0] cfg_rom_mask;
   logic [gbbc_pkg::RamBankFieldWidth-1:0] cfg_ram_mask;
   logic [gbbc_pkg::RomBankFieldWidth-1:0] rom_bank;
   logic [gbbc_pkg::RamBankFieldWidth-1:0] ram_bank;
   logic                                   ram_enabled;
   logic                                   mbc1_ram_mode;

   queued_access_type pending_accesses[$];
   mem_access_type    expected_accesses[$];
   queued_access_type current;
   int                accepted_count;
   int                returned_count;
   int                mismatch_count;
   int                send_idle_pct;
   int                rsp_stall_pct;
   int                phase_no;
   logic              hold_rsp;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic void set_rom_bank(input logic [gbbc_pkg::RomBankFieldWidth-1:0] bank);
      rom_bank = bank & cfg_rom_mask;
   endfunction

   function automatic void set_ram_bank(input logic [gbbc_pkg::RamBankFieldWidth-1:0] bank);
      ram_bank = bank & cfg_ram_mask;
   endfunction

   // Applies one bus access to the bank registers and returns the memory access it causes.
   function automatic mem_access_type map_access(input bus_access_type a);
      mem_access_type                    r;
      logic [3:0]                        hi;
      logic [2:0]                        grp;
      logic [gbbc_pkg::BusDataWidth-1:0] v;
      r   = '0;
      hi  = a.bus_address[15:12];
      grp = a.bus_address[15:13];
      v   = a.bus_data;
      if (a.action == ActRead) begin
         if (hi < 4'h4) begin
            r.access_kind    = gbbc_pkg::KindRomRead;
            r.memory_address = gbbc_pkg::MemAddrWidth'(a.bus_address);
         end else if (hi < 4'h8) begin
            r.access_kind    = gbbc_pkg::KindRomRead;
            r.memory_address = {rom_bank, a.bus_address[13:0]};
         end else if (grp == gbbc_pkg::RamWindow && ram_enabled) begin
            r.access_kind    = gbbc_pkg::KindRamRead;
            r.memory_address = {4'b0000, ram_bank, a.bus_address[12:0]};
         end
      end else if (cfg_mapper < gbbc_pkg::MapMbc1 || cfg_mapper > gbbc_pkg::MapMbc5) begin
         r = '0;
      end else if (grp == gbbc_pkg::RamWindow) begin
         if (ram_enabled) begin
            r.access_kind    = gbbc_pkg::KindRamWrite;
            r.memory_address = {4'b0000, ram_bank, a.bus_address[12:0]};
            r.write_byte     = v;
         end
      end else begin
         case (cfg_mapper) inside
            gbbc_pkg::MapMbc1: begin
               case (grp)
                  gbbc_pkg::GrpEnable: ram_enabled = (v[3:0] == gbbc_pkg::RamEnableKey);
                  gbbc_pkg::GrpRomBank: begin
                     set_rom_bank({2'b00, rom_bank[6:5], (v[4:0] == 5'd0) ? 5'd1 : v[4:0]});
                  end
                  gbbc_pkg::GrpUpper: begin
                     if (mbc1_ram_mode) set_ram_bank({4'b0000, v[1:0]});
                     else set_rom_bank({2'b00, v[1:0], rom_bank[4:0]});
                  end
                  gbbc_pkg::GrpMode: mbc1_ram_mode = v[0];
                  default: ;
               endcase
            end
            gbbc_pkg::MapMbc2: begin
               if (hi < 4'h4) begin
                  if (a.bus_address[8]) ram_enabled = (v[3:0] == gbbc_pkg::RamEnableKey);
                  else set_rom_bank((v[3:0] == 4'd0) ? 9'd1 : {5'b00000, v[3:0]});
               end
            end
            gbbc_pkg::MapMbc3, gbbc_pkg::MapMbc3Timer: begin
               case (grp)
                  gbbc_pkg::GrpEnable: ram_enabled = (v[3:0] == gbbc_pkg::RamEnableKey);
                  gbbc_pkg::GrpRomBank:
                     set_rom_bank((v[6:0] == 7'd0) ? 9'd1 : {2'b00, v[6:0]});
                  gbbc_pkg::GrpUpper: set_ram_bank({2'b00, v[3:0]});
                  default: ;
               endcase
            end
            default: begin
               case (hi) inside
                  gbbc_pkg::Mbc5EnableLo, gbbc_pkg::Mbc5EnableHi:
                     ram_enabled = (v[3:0] == gbbc_pkg::RamEnableKey);
                  gbbc_pkg::Mbc5RomLow: set_rom_bank({rom_bank[8], v});
                  gbbc_pkg::Mbc5RomHigh: set_rom_bank({v[0], rom_bank[7:0]});
                  gbbc_pkg::Mbc5RamLo, gbbc_pkg::Mbc5RamHi: set_ram_bank({2'b00, v[3:0]});
                  default: ;
               endcase
            end
         endcase
      end
      return r;
   endfunction

   function automatic bus_access_type random_access();
      bus_access_type a;
      int             pick;
      pick       = $urandom_range(99);
      a.action   = 1'($urandom_range(1));
      a.bus_data = 8'($urandom);
      if (pick < 30) begin
         a.bus_address = 16'($urandom_range(16'h7FFF));
         if ($urandom_range(1) == 1) a.bus_data = 8'($urandom_range(3));
      end else if (pick < 55) begin
         a.bus_address = {gbbc_pkg::RamWindow, 13'($urandom)};
      end else if (pick < 70) begin
         a.action      = ActWrite;
         a.bus_address = {3'b000, 13'($urandom)};
         if ($urandom_range(9) < 6) a.bus_data[3:0] = gbbc_pkg::RamEnableKey;
      end else if (pick < 85) begin
         a.action      = ActRead;
         a.bus_address = {2'b01, 14'($urandom)};
      end else begin
         a.bus_address = 16'($urandom);
      end
      return a;
   endfunction

   task automatic queue_access(input bus_access_type beat, input bit after_drain = 1'b0);
      queued_access_type q;
      q.beat        = beat;
      q.after_drain = after_drain;
      pending_accesses.push_back(q);
   endtask

   task automatic write_csr(input logic [1:0] idx,
                            input logic [gbbc_pkg::CsrDataWidth-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         gbbc_pkg::RegMapperMode:  cfg_mapper   = value[gbbc_pkg::ModeWidth-1:0];
         gbbc_pkg::RegRomBankMask: cfg_rom_mask = value[gbbc_pkg::RomBankFieldWidth-1:0];
         gbbc_pkg::RegRamBankMask: cfg_ram_mask = value[gbbc_pkg::RamBankFieldWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic set_mapper(input logic [gbbc_pkg::ModeWidth-1:0] mode,
                             input logic [gbbc_pkg::RomBankFieldWidth-1:0] rom_mask,
                             input logic [gbbc_pkg::RamBankFieldWidth-1:0] ram_mask);
      write_csr(gbbc_pkg::RegMapperMode, gbbc_pkg::CsrDataWidth'(mode));
      write_csr(gbbc_pkg::RegRomBankMask, gbbc_pkg::CsrDataWidth'(rom_mask));
      write_csr(gbbc_pkg::RegRamBankMask, gbbc_pkg::CsrDataWidth'(ram_mask));
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_accesses.size() != 0 || req_bus.valid || accepted_count != returned_count);
      repeat (SettleCycles) @(negedge clock);
   endtask

   always @(posedge clock) begin : drive_accesses
      logic taken;
      logic go;
      int   in_flight;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         taken = req_bus.valid && req_bus.ready;
         if (taken) begin
            expected_accesses.push_back(map_access(current.beat));
            accepted_count <= accepted_count + 1;
         end
         if (!req_bus.valid || taken) begin
            in_flight = accepted_count + int'(taken) - returned_count;
            go = pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct;
            if (go && pending_accesses[0].after_drain && in_flight != 0) go = 1'b0;
            if (go) begin
               current = pending_accesses.pop_front();
               req_bus.valid <= 1'b1;
               {req_bus.action, req_bus.bus_address, req_bus.bus_data} <= current.beat;
            end else begin
               req_bus.valid <= 1'b0;
               {req_bus.action, req_bus.bus_address, req_bus.bus_data} <= 25'($urandom);
            end
         end
      end
   end

   always @(posedge clock) begin : check_results
      mem_access_type got;
      mem_access_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.access_kind, rsp_bus.memory_address, rsp_bus.write_byte};
            returned_count <= returned_count + 1;
            if (expected_accesses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= ReportLimit)
                  $display("Unexpected result beat: kind %0d address %06h byte %02h",
                           got.access_kind, got.memory_address, got.write_byte);
            end else begin
               want = expected_accesses.pop_front();
               if (got.access_kind !== want.access_kind ||
                   got.memory_address !== want.memory_address ||
                   got.write_byte !== want.write_byte) begin
                  mismatch_count++;
                  if (mismatch_count <= ReportLimit)
                     $display("Result beat %0d: expected kind %0d address %06h byte %02h, %s",
                              returned_count, want.access_kind, want.memory_address,
                              want.write_byte,
                              $sformatf("got kind %0d address %06h byte %02h",
                                        got.access_kind, got.memory_address, got.write_byte));
               end
            end
         end
         rsp_bus.ready <= !hold_rsp && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // The result side holds off long enough for the controller to back up into its input.
   initial begin : rsp_holdoff
      wait (phase_no == HoldPhase);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HoldCycles) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin : run_timeout
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      reset               = 1'b1;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      req_bus.valid       = 1'b0;
      req_bus.action      = 1'b0;
      req_bus.bus_address = '0;
      req_bus.bus_data    = '0;
      rsp_bus.ready       = 1'b0;
      hold_rsp            = 1'b0;
      accepted_count      = 0;
      returned_count      = 0;
      mismatch_count      = 0;
      send_idle_pct       = 0;
      rsp_stall_pct       = 0;
      phase_no            = -1;
      cfg_mapper          = gbbc_pkg::MapNone;
      cfg_rom_mask        = gbbc_pkg::RomMaskReset;
      cfg_ram_mask        = gbbc_pkg::RamMaskReset;
      rom_bank            = 9'd1;
      ram_bank            = '0;
      ram_enabled         = 1'b0;
      mbc1_ram_mode       = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // With no mapper, reads still map and every write is dropped.
      @(negedge clock);
      queue_access({ActRead, 16'h0000, 8'h00});
      queue_access({ActRead, 16'h3FFF, 8'hFF});
      queue_access({ActRead, 16'h4000, 8'h00});
      queue_access({ActRead, 16'h7FFF, 8'h00});
      queue_access({ActRead, 16'hA000, 8'h00});
      queue_access({ActRead, 16'hFFFF, 8'h00});
      queue_access({ActWrite, 16'h2000, 8'h00});
      queue_access({ActWrite, 16'h0000, 8'h0A});
      queue_access({ActRead, 16'hBFFF, 8'h00});
      wait_drained();

      set_mapper(gbbc_pkg::MapMbc1, gbbc_pkg::RomMaskReset, gbbc_pkg::RamMaskReset);
      @(negedge clock);
      queue_access({ActWrite, 16'h0000, 8'h0A});
      queue_access({ActWrite, 16'hA123, 8'hFF});
      queue_access({ActRead, 16'hBFFF, 8'h00});
      queue_access({ActWrite, 16'h2000, 8'h00});
      queue_access({ActRead, 16'h4000, 8'h00});
      queue_access({ActWrite, 16'h4000, 8'h03});
      queue_access({ActRead, 16'h7FFF, 8'h00});
      queue_access({ActWrite, 16'h6000, 8'h01});
      queue_access({ActWrite, 16'h4000, 8'h02});
      queue_access({ActRead, 16'hA000, 8'h00});
      queue_access({ActWrite, 16'h0000, 8'h0B});
      queue_access({ActRead, 16'hA000, 8'h00});
      wait_drained();

      set_mapper(gbbc_pkg::MapMbc2, gbbc_pkg::RomMaskReset, gbbc_pkg::RamMaskReset);
      @(negedge clock);
      queue_access({ActWrite, 16'h0100, 8'h0A});
      queue_access({ActWrite, 16'h0000, 8'h00});
      queue_access({ActRead, 16'h4000, 8'h00});
      wait_drained();

      set_mapper(gbbc_pkg::MapMbc5, gbbc_pkg::RomMaskReset, gbbc_pkg::RamMaskReset);
      @(negedge clock);
      queue_access({ActWrite, 16'h3000, 8'h01});
      queue_access({ActWrite, 16'h2000, 8'h00});
      queue_access({ActRead, 16'h4000, 8'h00});

      for (int p = 0; p < PhaseCount; p++) begin
         wait_drained();
         set_mapper(PhaseMapper[p], PhaseRomMask[p], PhaseRamMask[p]);
         @(negedge clock);
         phase_no      = p;
         send_idle_pct = SendIdle[p % 4];
         rsp_stall_pct = RecvStall[p % 4];
         for (int i = 0; i < RandomPerPhase; i++) queue_access(random_access(), i == DrainIndex);
      end
      wait_drained();

      $display("Checked %0d bus accesses over mapper modes none to MBC5 with bank masks %s",
               accepted_count, "from empty to full.");
      $display("Sender idling, receiver stalls, a long result hold-off and a drain pause all ran.");
      if (mismatch_count == 0 && expected_accesses.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
